FILE: hdl/fca_pkg.sv
// Shared types and constants for the FAT16 cluster allocator.
// Used by the table memory, the register block and the request engine.
package fca_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CL_W        = 16;
    localparam int SPAN_W      = CL_W + 1;

    localparam logic [CL_W-1:0]  END_OF_CHAIN    = 16'hFFFF;
    localparam logic [CL_W-1:0]  FIRST_CLUSTER   = 16'd2;
    localparam logic [CL_W-1:0]  CLUSTER_COUNT_RST = 16'd65524;

    localparam logic [2:0] KIND_READ  = 3'd0;
    localparam logic [2:0] KIND_WRITE = 3'd1;
    localparam logic [2:0] KIND_ALLOC = 3'd2;
    localparam logic [2:0] KIND_FREE  = 3'd3;
    localparam logic [2:0] KIND_COUNT = 3'd4;

    localparam logic REG_CLUSTER_COUNT = 1'b0;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CL_W-1:0]   wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

    function automatic logic in_table(input logic [CL_W-1:0] cl);
        return ({1'b0, cl} < SPAN_W'(TABLE_DEPTH));
    endfunction

endpackage

FILE: hdl/fca_table_ram.sv
// Cluster table storage: one write port and one registered read port.
// Depends on fca_pkg for the depth and the request structure.
module fca_table_ram
(
    input  logic                    clk,
    input  fca_pkg::mem_req_t       req,
    output logic [fca_pkg::CL_W-1:0] rd_data
);

    logic [fca_pkg::CL_W-1:0] mem [fca_pkg::TABLE_DEPTH];
    logic [fca_pkg::CL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/fca_apb_regs.sv
// APB-style configuration register holding the cluster count.
// Depends on fca_pkg for register indices and reset values.
module fca_apb_regs
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output logic [fca_pkg::CL_W-1:0] cluster_count
);

    logic [fca_pkg::CL_W-1:0] cluster_count_reg;
    logic                     wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == fca_pkg::REG_CLUSTER_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg <= fca_pkg::CLUSTER_COUNT_RST;
        end
        else if (wr_hit)
        begin
            cluster_count_reg <= pwdata[fca_pkg::CL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == fca_pkg::REG_CLUSTER_COUNT) ?
                    {16'd0, cluster_count_reg} : 32'd0;
    assign cluster_count = cluster_count_reg;

endmodule

FILE: hdl/fca_engine.sv
// Request sequencer: clearing pass, table walks and the result register.
// Depends on fca_pkg and drives the table memory through fca_pkg::mem_req_t.
module fca_engine
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [fca_pkg::CL_W-1:0]  cluster_count,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [2:0]                kind,
    input  logic [fca_pkg::CL_W-1:0]  cluster,
    input  logic [fca_pkg::CL_W-1:0]  value,
    input  logic [fca_pkg::CL_W-1:0]  link_from,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      status,
    output logic [fca_pkg::CL_W-1:0]  new_cluster,
    output logic [fca_pkg::CL_W-1:0]  entry_value,
    output logic [fca_pkg::CL_W-1:0]  free_total,
    output fca_pkg::mem_req_t         mem_req,
    input  logic [fca_pkg::CL_W-1:0]  rd_data
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_READ_WAIT,
        S_WRITE,
        S_ALLOC,
        S_LINK,
        S_FREE_RD,
        S_FREE_EVAL,
        S_COUNT,
        S_DONE
    } state_t;

    localparam int CL_W   = fca_pkg::CL_W;
    localparam int SPAN_W = fca_pkg::SPAN_W;
    localparam int ADDR_W = fca_pkg::ADDR_W;

    state_t              state_reg,        state_next;
    logic [ADDR_W-1:0]   clr_addr_reg,     clr_addr_next;
    logic [CL_W-1:0]     hint_reg,         hint_next;
    logic [CL_W-1:0]     cl_reg,           cl_next;
    logic [CL_W-1:0]     value_reg,        value_next;
    logic [CL_W-1:0]     link_reg,         link_next;
    logic [SPAN_W-1:0]   scan_addr_reg,    scan_addr_next;
    logic [SPAN_W-1:0]   scan_left_reg,    scan_left_next;
    logic                pend_valid_reg,   pend_valid_next;
    logic [CL_W-1:0]     pend_addr_reg,    pend_addr_next;
    logic                res_status_reg,   res_status_next;
    logic [CL_W-1:0]     res_new_reg,      res_new_next;
    logic [CL_W-1:0]     res_entry_reg,    res_entry_next;
    logic [CL_W-1:0]     res_total_reg,    res_total_next;
    logic                out_valid_reg,    out_valid_next;
    logic                status_reg,       status_next;
    logic [CL_W-1:0]     new_cluster_reg,  new_cluster_next;
    logic [CL_W-1:0]     entry_value_reg,  entry_value_next;
    logic [CL_W-1:0]     free_total_reg,   free_total_next;

    logic [SPAN_W-1:0]   cc_plus;
    logic [SPAN_W-1:0]   last;
    logic [SPAN_W-1:0]   span;
    logic [SPAN_W-1:0]   alloc_cur;
    logic                cl_valid;
    logic                accept;
    fca_pkg::mem_req_t   req;

    assign cc_plus  = {1'b0, cluster_count} + SPAN_W'(1);
    assign last     = (cc_plus > SPAN_W'(fca_pkg::TABLE_DEPTH - 1)) ?
                      SPAN_W'(fca_pkg::TABLE_DEPTH - 1) : cc_plus;
    assign span     = (last >= SPAN_W'(2)) ? (last - SPAN_W'(1)) : SPAN_W'(0);
    assign alloc_cur = ((scan_addr_reg > last) || (scan_addr_reg < SPAN_W'(2))) ?
                       SPAN_W'(fca_pkg::FIRST_CLUSTER) : scan_addr_reg;
    assign cl_valid = (cl_reg >= fca_pkg::FIRST_CLUSTER) && ({1'b0, cl_reg} <= last);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        hint_next        = hint_reg;
        cl_next          = cl_reg;
        value_next       = value_reg;
        link_next        = link_reg;
        scan_addr_next   = scan_addr_reg;
        scan_left_next   = scan_left_reg;
        pend_valid_next  = pend_valid_reg;
        pend_addr_next   = pend_addr_reg;
        res_status_next  = res_status_reg;
        res_new_next     = res_new_reg;
        res_entry_next   = res_entry_reg;
        res_total_next   = res_total_reg;
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        new_cluster_next = new_cluster_reg;
        entry_value_next = entry_value_reg;
        free_total_next  = free_total_reg;
        req              = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                req.wr_en     = 1'b1;
                req.wr_addr   = clr_addr_reg;
                req.wr_data   = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(fca_pkg::TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cl_next         = cluster;
                    value_next      = value;
                    link_next       = link_from;
                    pend_valid_next = 1'b0;
                    res_status_next = 1'b0;
                    res_new_next    = '0;
                    res_entry_next  = '0;
                    res_total_next  = '0;
                    scan_addr_next  = {1'b0, hint_reg};
                    scan_left_next  = span;
                    unique case (kind)
                        fca_pkg::KIND_READ:  state_next = S_READ;
                        fca_pkg::KIND_WRITE: state_next = S_WRITE;
                        fca_pkg::KIND_ALLOC: state_next = S_ALLOC;
                        fca_pkg::KIND_FREE:
                        begin
                            scan_left_next = span + SPAN_W'(1);
                            state_next     = S_FREE_RD;
                        end
                        fca_pkg::KIND_COUNT:
                        begin
                            scan_addr_next = SPAN_W'(fca_pkg::FIRST_CLUSTER);
                            state_next     = S_COUNT;
                        end
                        default:             state_next = S_DONE;
                    endcase
                end
            end
            S_READ:
            begin
                if (fca_pkg::in_table(cl_reg))
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = cl_reg[ADDR_W-1:0];
                    state_next  = S_READ_WAIT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ_WAIT:
            begin
                res_entry_next = rd_data;
                state_next     = S_DONE;
            end
            S_WRITE:
            begin
                if (fca_pkg::in_table(cl_reg))
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = cl_reg[ADDR_W-1:0];
                    req.wr_data = value_reg;
                end
                state_next = S_DONE;
            end
            S_ALLOC:
            begin
                if (pend_valid_reg && (rd_data == '0))
                begin
                    req.wr_en    = 1'b1;
                    req.wr_addr  = pend_addr_reg[ADDR_W-1:0];
                    req.wr_data  = fca_pkg::END_OF_CHAIN;
                    hint_next    = pend_addr_reg + CL_W'(1);
                    res_new_next = pend_addr_reg;
                    state_next   = (link_reg != '0) ? S_LINK : S_DONE;
                end
                else if (scan_left_reg != '0)
                begin
                    req.rd_en       = 1'b1;
                    req.rd_addr     = alloc_cur[ADDR_W-1:0];
                    pend_valid_next = 1'b1;
                    pend_addr_next  = alloc_cur[CL_W-1:0];
                    scan_addr_next  = alloc_cur + SPAN_W'(1);
                    scan_left_next  = scan_left_reg - SPAN_W'(1);
                end
                else if (pend_valid_reg)
                begin
                    pend_valid_next = 1'b0;
                end
                else
                begin
                    res_status_next = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_LINK:
            begin
                if (fca_pkg::in_table(link_reg))
                begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = link_reg[ADDR_W-1:0];
                    req.wr_data = res_new_reg;
                end
                state_next = S_DONE;
            end
            S_FREE_RD:
            begin
                if ((scan_left_reg != '0) && cl_valid)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = cl_reg[ADDR_W-1:0];
                    state_next  = S_FREE_EVAL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FREE_EVAL:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = cl_reg[ADDR_W-1:0];
                req.wr_data = '0;
                if (cl_reg < hint_reg)
                begin
                    hint_next = cl_reg;
                end
                cl_next        = rd_data;
                scan_left_next = scan_left_reg - SPAN_W'(1);
                state_next     = S_FREE_RD;
            end
            S_COUNT:
            begin
                if (pend_valid_reg && (rd_data == '0))
                begin
                    res_total_next = res_total_reg + CL_W'(1);
                end
                if (scan_left_reg != '0)
                begin
                    req.rd_en       = 1'b1;
                    req.rd_addr     = scan_addr_reg[ADDR_W-1:0];
                    pend_valid_next = 1'b1;
                    scan_addr_next  = scan_addr_reg + SPAN_W'(1);
                    scan_left_next  = scan_left_reg - SPAN_W'(1);
                end
                else if (pend_valid_reg)
                begin
                    pend_valid_next = 1'b0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    new_cluster_next = res_new_reg;
                    entry_value_next = res_entry_reg;
                    free_total_next  = res_total_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            hint_reg       <= fca_pkg::FIRST_CLUSTER;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            hint_reg       <= hint_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cl_reg          <= cl_next;
        value_reg       <= value_next;
        link_reg        <= link_next;
        scan_addr_reg   <= scan_addr_next;
        scan_left_reg   <= scan_left_next;
        pend_addr_reg   <= pend_addr_next;
        res_status_reg  <= res_status_next;
        res_new_reg     <= res_new_next;
        res_entry_reg   <= res_entry_next;
        res_total_reg   <= res_total_next;
        status_reg      <= status_next;
        new_cluster_reg <= new_cluster_next;
        entry_value_reg <= entry_value_next;
        free_total_reg  <= free_total_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign new_cluster = new_cluster_reg;
    assign entry_value = entry_value_reg;
    assign free_total  = free_total_reg;
    assign mem_req     = req;

`ifndef ASSERT_OFF
    a_no_same_entry_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr_en && req.rd_en && (req.wr_addr == req.rd_addr)))
        else $error("table read and write hit the same entry in one cycle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted transfer did not start a request");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && out_stall)) |->
        $past(state_reg == S_DONE))
        else $error("result loaded outside the completion state");
`endif

endmodule

FILE: hdl/fat16_cluster_allocator.sv
// Top level of the FAT16 cluster allocator.
// Depends on fca_pkg, fca_table_ram, fca_apb_regs and fca_engine.
//
// Requests arrive on the input channel (in_valid, in_stall, kind, cluster, value,
// link_from); each accepted transfer yields exactly one result transfer on the
// output channel (out_valid, out_stall, status, new_cluster, entry_value,
// free_total). A transfer takes place when valid is high and stall is low.
// One request is handled at a time, with the table held in one memory whose
// read data arrives in the cycle after the address.
// An allocate inspects entries starting at the search hint and, when link_from
// is nonzero, then writes the link; free walks the chain one link at a time;
// count free reads every entry from cluster 2 up to cluster_count + 1, at most 65535.
// The next request can be taken in the cycle after a result has been loaded.
// A new request is taken once the previous one has reached the output register,
// even while that result is still stalled by the receiver; the engine then
// waits before it can deliver its own result.
// After reset the table is cleared one entry per cycle, all 65536 entries,
// during which in_stall stays high; the APB register accepts writes throughout.
// cluster_count must be written only while no request is outstanding.
module fat16_cluster_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [15:0] cluster,
    input  logic [15:0] value,
    input  logic [15:0] link_from,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [15:0] new_cluster,
    output logic [15:0] entry_value,
    output logic [15:0] free_total
);

    logic [fca_pkg::CL_W-1:0] cluster_count;
    logic [fca_pkg::CL_W-1:0] rd_data;
    fca_pkg::mem_req_t        mem_req;

    fca_apb_regs u_regs
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .cluster_count (cluster_count)
    );

    fca_table_ram u_table
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    fca_engine u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cluster_count (cluster_count),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .cluster       (cluster),
        .value         (value),
        .link_from     (link_from),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .new_cluster   (new_cluster),
        .entry_value   (entry_value),
        .free_total    (free_total),
        .mem_req       (mem_req),
        .rd_data       (rd_data)
    );

endmodule
